### hdl/pps_pkg.sv
// package for the preemptive priority scheduler
// entry type, request and status codes, queue sizes; no dependencies
package pps_pkg;

    localparam int READY_DEPTH = 16;
    localparam int FIFO_DEPTH  = 4;
    localparam int RA_W        = $clog2(READY_DEPTH);
    localparam int RS_W        = $clog2(READY_DEPTH + 1);
    localparam int FA_W        = $clog2(FIFO_DEPTH);
    localparam int FS_W        = $clog2(FIFO_DEPTH + 1);

    typedef struct packed {
        logic [15:0] pid;
        logic [7:0]  prio;
        logic [19:0] mem;
    } t_entry;

    typedef enum logic [2:0] {
        REQ_ADD        = 3'd0,
        REQ_PRINT      = 3'd1,
        REQ_PRINT_DONE = 3'd2,
        REQ_DISK       = 3'd3,
        REQ_DISK_DONE  = 3'd4,
        REQ_TERM       = 3'd5
    } t_req;

    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_NOMEM      = 3'd1;
    localparam logic [2:0] ST_READY_FULL = 3'd2;
    localparam logic [2:0] ST_PRINT_FULL = 3'd3;
    localparam logic [2:0] ST_DISK_FULL  = 3'd4;
    localparam logic [2:0] ST_NOTHING    = 3'd5;
    localparam logic [2:0] ST_BAD        = 3'd6;

    localparam logic [1:0] CFG_TOTAL_MEM = 2'd0;
    localparam logic [1:0] CFG_PRINT_LIM = 2'd1;
    localparam logic [1:0] CFG_DISK_LIM  = 2'd2;

endpackage

### hdl/pps_ready_mem.sv
// ready queue storage: one write port, one registered read port
// uses pps_pkg
module pps_ready_mem (
    input  logic                    i_clk,
    input  logic                    i_we,
    input  logic [pps_pkg::RA_W-1:0] i_waddr,
    input  pps_pkg::t_entry         i_wdata,
    input  logic [pps_pkg::RA_W-1:0] i_raddr,
    output pps_pkg::t_entry         o_rdata
);

    pps_pkg::t_entry r_mem [pps_pkg::READY_DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

### hdl/pps_io_fifo.sv
// circular job queue for one i/o device
// uses pps_pkg
module pps_io_fifo (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_push,
    input  pps_pkg::t_entry         i_push_data,
    input  logic                    i_pop,
    output pps_pkg::t_entry         o_head,
    output logic [pps_pkg::FS_W-1:0] o_fill
);

    pps_pkg::t_entry            r_mem [pps_pkg::FIFO_DEPTH];
    logic [pps_pkg::FA_W-1:0]   r_wp;
    logic [pps_pkg::FA_W-1:0]   r_rp;
    logic [pps_pkg::FS_W-1:0]   r_fill;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_push_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp   <= '0;
            r_rp   <= '0;
            r_fill <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == pps_pkg::FA_W'(pps_pkg::FIFO_DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= (r_rp == pps_pkg::FA_W'(pps_pkg::FIFO_DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_fill <= r_fill + 1'b1;
            end else if (i_pop && !i_push) begin
                r_fill <= r_fill - 1'b1;
            end
        end
    end

    assign o_head = r_mem[r_rp];
    assign o_fill = r_fill;

endmodule

### hdl/preemptive_priority_scheduler_top.sv
// top level of the preemptive priority scheduler
// a rejected request goes from the transfer to S_RESP and then to the output register;
// an insert steps through S_INS_RD and S_INS_WR for each ready entry it moves, a pop
// through S_POP_RD and S_POP_WR for each entry behind the head, set by the single read
// port of the ready queue memory; output stalls hold the result in S_RESP
// one request at a time; synchronous active-low reset empties all queues
module preemptive_priority_scheduler_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,  // req_priority, req_memory
    input  logic [2:0]  s_axis_tuser,  // req_type
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // cpu_busy, running_pid, running_priority, memory_used, ready_count,
    // printer_count, disk_count, new_pid, done_pid
    output logic [87:0] m_axis_tdata,
    output logic [2:0]  m_axis_tuser,  // status
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_addr,
    input  logic [19:0] i_cfg_data
);

    typedef enum logic [7:0] {
        S_IDLE    = 8'b0000_0001,
        S_INS_RD  = 8'b0000_0010,
        S_INS_WR  = 8'b0000_0100,
        S_POP_RD  = 8'b0000_1000,
        S_POP_WR  = 8'b0001_0000,
        S_SCH_RD  = 8'b0010_0000,
        S_SCH_CMP = 8'b0100_0000,
        S_RESP    = 8'b1000_0000
    } t_state;

    t_state                       r_state;
    logic [19:0]                  r_total;
    logic [2:0]                   r_plim;
    logic [2:0]                   r_dlim;
    pps_pkg::t_entry              r_run;
    logic                         r_run_valid;
    pps_pkg::t_entry              r_ins;
    logic [pps_pkg::RS_W-1:0]     r_size;
    logic [pps_pkg::RS_W-1:0]     r_k;
    logic                         r_sched;
    logic                         r_pre;
    logic [19:0]                  r_used;
    logic [15:0]                  r_pid;
    logic [2:0]                   r_status;
    logic [15:0]                  r_new_id;
    logic [15:0]                  r_done_id;

    logic                         accept;
    logic [2:0]                   req;
    logic [7:0]                   req_prio;
    logic [19:0]                  req_mem;
    logic                         mem_we;
    logic [pps_pkg::RA_W-1:0]     mem_wa;
    pps_pkg::t_entry              mem_wd;
    logic [pps_pkg::RA_W-1:0]     mem_ra;
    pps_pkg::t_entry              mem_rd;
    logic                         p_push, p_pop, d_push, d_pop;
    pps_pkg::t_entry              p_head, d_head;
    logic [pps_pkg::FS_W-1:0]     p_fill, d_fill;
    logic [pps_pkg::FS_W-1:0]     p_lim, d_lim;
    logic [pps_pkg::RS_W-1:0]     k_dec;
    logic [pps_pkg::RS_W-1:0]     size_dec;
    logic [20:0]                  mem_sum;
    logic [15:0]                  n_pid;
    logic                         ready_full;
    logic                         out_free;

    assign accept     = s_axis_tvalid && s_axis_tready;
    assign req        = s_axis_tuser;
    assign req_prio   = s_axis_tdata[7:0];
    assign req_mem    = s_axis_tdata[27:8];
    assign s_axis_tready = (r_state == S_IDLE);
    assign out_free   = !m_axis_tvalid || m_axis_tready;
    assign k_dec      = r_k - 1'b1;
    assign size_dec   = r_size - 1'b1;
    assign mem_sum    = {1'b0, req_mem} + {1'b0, r_used};
    assign n_pid      = (r_pid == 16'hFFFF) ? 16'd1 : r_pid + 1'b1;
    assign ready_full = (r_size >= pps_pkg::RS_W'(pps_pkg::READY_DEPTH));
    assign p_lim = ({1'b0, r_plim} < 4'(pps_pkg::FIFO_DEPTH))
                 ? pps_pkg::FS_W'(r_plim) : pps_pkg::FS_W'(pps_pkg::FIFO_DEPTH);
    assign d_lim = ({1'b0, r_dlim} < 4'(pps_pkg::FIFO_DEPTH))
                 ? pps_pkg::FS_W'(r_dlim) : pps_pkg::FS_W'(pps_pkg::FIFO_DEPTH);

    assign p_push = accept && (req == pps_pkg::REQ_PRINT) && r_run_valid && (p_fill < p_lim);
    assign d_push = accept && (req == pps_pkg::REQ_DISK) && r_run_valid && (d_fill < d_lim);
    assign p_pop  = accept && (req == pps_pkg::REQ_PRINT_DONE) && (p_fill != '0) && !ready_full;
    assign d_pop  = accept && (req == pps_pkg::REQ_DISK_DONE) && (d_fill != '0) && !ready_full;

    pps_io_fifo u_print (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(p_push), .i_push_data(r_run),
        .i_pop(p_pop), .o_head(p_head), .o_fill(p_fill)
    );

    pps_io_fifo u_disk (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(d_push), .i_push_data(r_run),
        .i_pop(d_pop), .o_head(d_head), .o_fill(d_fill)
    );

    pps_ready_mem u_ready (
        .i_clk(i_clk), .i_we(mem_we), .i_waddr(mem_wa), .i_wdata(mem_wd),
        .i_raddr(mem_ra), .o_rdata(mem_rd)
    );

    always_comb begin
        mem_we = 1'b0;
        mem_wa = r_k[pps_pkg::RA_W-1:0];
        mem_wd = r_ins;
        mem_ra = '0;
        unique case (r_state)
            S_INS_RD: begin
                mem_ra = k_dec[pps_pkg::RA_W-1:0];
                mem_we = (r_k == '0);
            end
            S_INS_WR: begin
                mem_we = 1'b1;
                if (!(mem_rd.prio > r_ins.prio)) begin
                    mem_wd = mem_rd;
                end
            end
            S_POP_RD: begin
                mem_ra = r_k[pps_pkg::RA_W-1:0];
            end
            S_POP_WR: begin
                mem_we = 1'b1;
                mem_wa = k_dec[pps_pkg::RA_W-1:0];
                mem_wd = mem_rd;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total <= 20'hFFFFF;
            r_plim  <= 3'd4;
            r_dlim  <= 3'd4;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                pps_pkg::CFG_TOTAL_MEM: r_total <= i_cfg_data;
                pps_pkg::CFG_PRINT_LIM: r_plim  <= i_cfg_data[2:0];
                pps_pkg::CFG_DISK_LIM:  r_dlim  <= i_cfg_data[2:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tvalid <= 1'b0;
        end else if ((r_state == S_RESP) && out_free) begin
            m_axis_tvalid <= 1'b1;
        end else if (m_axis_tready) begin
            m_axis_tvalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_run         <= '0;
            r_run_valid   <= 1'b0;
            r_size        <= '0;
            r_k           <= '0;
            r_sched       <= 1'b0;
            r_pre         <= 1'b0;
            r_used        <= '0;
            r_pid         <= 16'd1;
            r_status      <= pps_pkg::ST_OK;
            r_new_id      <= '0;
            r_done_id     <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_new_id  <= '0;
                        r_done_id <= '0;
                        r_status  <= pps_pkg::ST_OK;
                        r_k       <= r_size;
                        r_sched   <= 1'b1;
                        r_state   <= S_RESP;
                        case (req)
                            pps_pkg::REQ_ADD: begin
                                if (mem_sum > {1'b0, r_total}) begin
                                    r_status <= pps_pkg::ST_NOMEM;
                                end else if (ready_full) begin
                                    r_status <= pps_pkg::ST_READY_FULL;
                                end else begin
                                    r_used   <= mem_sum[19:0];
                                    r_ins    <= '{pid: r_pid, prio: req_prio, mem: req_mem};
                                    r_new_id <= r_pid;
                                    r_pid    <= n_pid;
                                    r_state  <= S_INS_RD;
                                end
                            end
                            pps_pkg::REQ_PRINT, pps_pkg::REQ_DISK: begin
                                if (!r_run_valid) begin
                                    r_status <= pps_pkg::ST_NOTHING;
                                end else if (!(p_push || d_push)) begin
                                    r_status <= (req == pps_pkg::REQ_PRINT)
                                              ? pps_pkg::ST_PRINT_FULL : pps_pkg::ST_DISK_FULL;
                                end else begin
                                    r_run       <= '0;
                                    r_run_valid <= 1'b0;
                                    r_state     <= S_SCH_RD;
                                end
                            end
                            pps_pkg::REQ_PRINT_DONE, pps_pkg::REQ_DISK_DONE: begin
                                if ((req == pps_pkg::REQ_PRINT_DONE) ? (p_fill == '0)
                                                                      : (d_fill == '0)) begin
                                    r_status <= pps_pkg::ST_NOTHING;
                                end else if (ready_full) begin
                                    r_status <= pps_pkg::ST_READY_FULL;
                                end else begin
                                    r_ins     <= p_pop ? p_head : d_head;
                                    r_done_id <= p_pop ? p_head.pid : d_head.pid;
                                    r_state   <= S_INS_RD;
                                end
                            end
                            pps_pkg::REQ_TERM: begin
                                if (!r_run_valid) begin
                                    r_status <= pps_pkg::ST_NOTHING;
                                end else begin
                                    r_used <= (r_used >= r_run.mem) ? r_used - r_run.mem : '0;
                                    r_run       <= '0;
                                    r_run_valid <= 1'b0;
                                    r_state     <= S_SCH_RD;
                                end
                            end
                            default: r_status <= pps_pkg::ST_BAD;
                        endcase
                    end
                end
                S_INS_RD: begin
                    if (r_k == '0) begin
                        r_size  <= r_size + 1'b1;
                        r_state <= r_sched ? S_SCH_RD : S_RESP;
                    end else begin
                        r_state <= S_INS_WR;
                    end
                end
                S_INS_WR: begin
                    if (mem_rd.prio > r_ins.prio) begin
                        r_size  <= r_size + 1'b1;
                        r_state <= r_sched ? S_SCH_RD : S_RESP;
                    end else begin
                        r_k     <= k_dec;
                        r_state <= S_INS_RD;
                    end
                end
                S_SCH_RD: begin
                    r_state <= (r_size == '0) ? S_RESP : S_SCH_CMP;
                end
                S_SCH_CMP: begin
                    if (!r_run_valid || (mem_rd.prio > r_run.prio)) begin
                        r_ins       <= r_run;
                        r_pre       <= r_run_valid;
                        r_run       <= mem_rd;
                        r_run_valid <= 1'b1;
                        r_k         <= pps_pkg::RS_W'(1);
                        r_state     <= S_POP_RD;
                    end else begin
                        r_state <= S_RESP;
                    end
                end
                S_POP_RD: begin
                    if (r_k >= r_size) begin
                        r_size <= size_dec;
                        if (r_pre) begin
                            r_k     <= size_dec;
                            r_sched <= 1'b0;
                            r_state <= S_INS_RD;
                        end else begin
                            r_state <= S_RESP;
                        end
                    end else begin
                        r_state <= S_POP_WR;
                    end
                end
                S_POP_WR: begin
                    r_k     <= r_k + 1'b1;
                    r_state <= S_POP_RD;
                end
                S_RESP: begin
                    if (out_free) begin
                        m_axis_tuser  <= r_status;
                        m_axis_tdata  <= {r_done_id, r_new_id, d_fill, p_fill, r_size, r_used,
                                          r_run_valid ? r_run.prio : 8'd0,
                                          r_run_valid ? r_run.pid : 16'd0, r_run_valid};
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

### hdl/pps_checker.sv
// port-level checks for the preemptive priority scheduler
// attached to preemptive_priority_scheduler_top by bind
module pps_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [87:0] m_axis_tdata,
    input logic [2:0]  m_axis_tuser
);

    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tuser <= pps_pkg::ST_BAD))
        else $error("status out of range");

    a_idle_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tdata[0]) |-> (m_axis_tdata[24:1] == '0))
        else $error("idle cpu shows a process");

    a_ready_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[49:45] <= 5'(pps_pkg::READY_DEPTH)))
        else $error("ready count too large");

    a_ids_on_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (m_axis_tuser != pps_pkg::ST_OK)) |-> (m_axis_tdata[87:56] == '0))
        else $error("pid reported on failed request");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("stalled transfer changed");

endmodule

bind preemptive_priority_scheduler_top pps_checker u_pps_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
);

### tb/preemptive_priority_scheduler_checker.sv
// checker for the preemptive priority scheduler: watches both stream channels,
// predicts each result from a behavioral copy of the scheduler and compares
// depends on pps_pkg
`timescale 1ns / 100ps

module preemptive_priority_scheduler_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,
    input  logic [2:0]  s_axis_tuser,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [87:0] m_axis_tdata,
    input  logic [2:0]  m_axis_tuser,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_addr,
    input  logic [19:0] i_cfg_data,
    output int          o_errors,
    output int          o_pending
);

    typedef struct packed {
        logic [2:0]  status;
        logic [87:0] data;
    } t_sched_out;

    logic [19:0]     mem_total;
    logic [2:0]      prn_lim;
    logic [2:0]      dsk_lim;
    pps_pkg::t_entry rq[pps_pkg::READY_DEPTH];
    int              rq_n;
    pps_pkg::t_entry run_e;
    bit              run_v;
    logic [19:0]     mem_used;
    logic [15:0]     pid_next;
    pps_pkg::t_entry prn_q[$];
    pps_pkg::t_entry dsk_q[$];
    t_sched_out      outcome_q[$];

    task automatic rq_insert(input pps_pkg::t_entry e);
        int pos;
        pos = 0;
        for (int i = 0; i < rq_n; i++)
            if (rq[i].prio > e.prio) pos++;
        for (int i = rq_n; i > pos; i--) rq[i] = rq[i-1];
        rq[pos] = e;
        rq_n++;
    endtask

    task automatic rq_pop(output pps_pkg::t_entry e);
        e = rq[0];
        for (int i = 0; i + 1 < rq_n; i++) rq[i] = rq[i+1];
        rq_n--;
    endtask

    task automatic reschedule();
        pps_pkg::t_entry h;
        if (rq_n == 0) return;
        if (!run_v) begin
            rq_pop(run_e);
            run_v = 1'b1;
        end else if (rq[0].prio > run_e.prio) begin
            rq_pop(h);
            rq_insert(run_e);
            run_e = h;
        end
    endtask

    task automatic next_running();
        if (rq_n > 0) begin
            rq_pop(run_e);
            run_v = 1'b1;
        end else begin
            run_e = '0;
            run_v = 1'b0;
        end
    endtask

    task automatic predict_request(input logic [2:0] kind, input logic [7:0] prio,
                                   input logic [19:0] mem);
        logic [2:0]      st;
        logic [15:0]     nid, did;
        pps_pkg::t_entry e;
        t_sched_out      r;
        st  = pps_pkg::ST_BAD;
        nid = '0;
        did = '0;
        case (kind)
            pps_pkg::REQ_ADD: begin
                if ({1'b0, mem} + {1'b0, mem_used} > {1'b0, mem_total}) st = pps_pkg::ST_NOMEM;
                else if (rq_n >= pps_pkg::READY_DEPTH) st = pps_pkg::ST_READY_FULL;
                else begin
                    e = '{pid: pid_next, prio: prio, mem: mem};
                    mem_used = mem_used + mem;
                    rq_insert(e);
                    reschedule();
                    nid = pid_next;
                    pid_next = pid_next + 16'd1;
                    if (pid_next == 16'd0) pid_next = 16'd1;
                    st = pps_pkg::ST_OK;
                end
            end
            pps_pkg::REQ_PRINT, pps_pkg::REQ_DISK: begin
                int lim, fill;
                lim  = (kind == pps_pkg::REQ_PRINT) ? int'(prn_lim) : int'(dsk_lim);
                if (lim > pps_pkg::FIFO_DEPTH) lim = pps_pkg::FIFO_DEPTH;
                fill = (kind == pps_pkg::REQ_PRINT) ? prn_q.size() : dsk_q.size();
                if (!run_v) st = pps_pkg::ST_NOTHING;
                else if (fill >= lim)
                    st = (kind == pps_pkg::REQ_PRINT) ? pps_pkg::ST_PRINT_FULL
                                                      : pps_pkg::ST_DISK_FULL;
                else begin
                    if (kind == pps_pkg::REQ_PRINT) prn_q = {prn_q, run_e};
                    else dsk_q = {dsk_q, run_e};
                    next_running();
                    st = pps_pkg::ST_OK;
                end
            end
            pps_pkg::REQ_PRINT_DONE, pps_pkg::REQ_DISK_DONE: begin
                int fill;
                fill = (kind == pps_pkg::REQ_PRINT_DONE) ? prn_q.size() : dsk_q.size();
                if (fill == 0) st = pps_pkg::ST_NOTHING;
                else if (rq_n >= pps_pkg::READY_DEPTH) st = pps_pkg::ST_READY_FULL;
                else begin
                    e = (kind == pps_pkg::REQ_PRINT_DONE) ? prn_q.pop_front()
                                                          : dsk_q.pop_front();
                    rq_insert(e);
                    reschedule();
                    did = e.pid;
                    st = pps_pkg::ST_OK;
                end
            end
            pps_pkg::REQ_TERM: begin
                if (!run_v) st = pps_pkg::ST_NOTHING;
                else begin
                    mem_used = (mem_used >= run_e.mem) ? mem_used - run_e.mem : '0;
                    next_running();
                    st = pps_pkg::ST_OK;
                end
            end
            default: st = pps_pkg::ST_BAD;
        endcase
        r.status = st;
        r.data = {did, nid, 3'(dsk_q.size()), 3'(prn_q.size()), 5'(rq_n), mem_used,
                  run_v ? run_e.prio : 8'd0, run_v ? run_e.pid : 16'd0, run_v};
        outcome_q = {outcome_q, r};
    endtask

    always @(posedge i_clk) begin
        t_sched_out want;
        if (!i_rst_n) begin
            mem_total = 20'hFFFFF;
            prn_lim   = 3'd4;
            dsk_lim   = 3'd4;
            rq_n      = 0;
            run_e     = '0;
            run_v     = 1'b0;
            mem_used  = '0;
            pid_next  = 16'd1;
            prn_q.delete();
            dsk_q.delete();
            outcome_q.delete();
            o_errors  = 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    pps_pkg::CFG_TOTAL_MEM: mem_total = i_cfg_data;
                    pps_pkg::CFG_PRINT_LIM: prn_lim = i_cfg_data[2:0];
                    pps_pkg::CFG_DISK_LIM:  dsk_lim = i_cfg_data[2:0];
                    default: ;
                endcase
            end
            if (m_axis_tvalid && m_axis_tready) begin
                if (outcome_q.size() == 0) begin
                    o_errors++;
                    if (o_errors <= 10)
                        $display("unexpected transfer status=%0d data=%h",
                                 m_axis_tuser, m_axis_tdata);
                end else begin
                    want = outcome_q.pop_front();
                    if (want.status !== m_axis_tuser || want.data !== m_axis_tdata) begin
                        o_errors++;
                        if (o_errors <= 10)
                            $display("mismatch exp status=%0d data=%h got status=%0d data=%h",
                                     want.status, want.data, m_axis_tuser, m_axis_tdata);
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                predict_request(s_axis_tuser, s_axis_tdata[7:0], s_axis_tdata[27:8]);
        end
        o_pending = outcome_q.size();
    end

endmodule

### tb/preemptive_priority_scheduler_top_test.sv
// testbench top for the preemptive priority scheduler: clock, reset, stimulus,
// configuration phases and verdict; depends on pps_pkg and the checker module
`timescale 1ns / 100ps

module preemptive_priority_scheduler_top_test;

    localparam int WATCHDOG = 20000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;
    logic [2:0]  s_axis_tuser = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [87:0] m_axis_tdata;
    logic [2:0]  m_axis_tuser;
    logic        i_cfg_we = 1'b0;
    logic [1:0]  i_cfg_addr = '0;
    logic [19:0] i_cfg_data = '0;
    int          errors;
    int          pending;
    int          idle_cycles = 0;
    bit          hold_off = 1'b0;

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    preemptive_priority_scheduler_top dut (.*);

    preemptive_priority_scheduler_checker chk (
        .i_clk, .i_rst_n, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
        .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
        .i_cfg_we, .i_cfg_addr, .i_cfg_data, .o_errors(errors), .o_pending(pending)
    );

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG) begin
            $display("tb: failure");
            $finish;
        end
    end

    // receiver: random stall per transfer, or a long hold-off when asked
    initial begin
        int gap;
        forever begin
            @(posedge i_clk);
            if (hold_off) begin
                m_axis_tready <= 1'b0;
                repeat (600) @(posedge i_clk);
                hold_off = 1'b0;
            end
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
            if (gap > 0) begin
                m_axis_tready <= 1'b0;
                repeat (gap - 1) @(posedge i_clk);
                @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
            m_axis_tready <= 1'b0;
        end
    end

    task automatic send_req(input logic [2:0] kind, input logic [7:0] prio,
                            input logic [19:0] mem, input bit no_gap);
        int gap;
        gap = no_gap ? 0 : $urandom_range(0, 12);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= {4'b0, mem, prio};
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending > 0) @(posedge i_clk);
        repeat (80) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [1:0] idx, input logic [19:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    task automatic random_phase(input int count, input bit tight);
        logic [2:0]  kind;
        logic [19:0] mem;
        int          pick;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 35) kind = pps_pkg::REQ_ADD;
            else if (pick < 45) kind = pps_pkg::REQ_PRINT;
            else if (pick < 55) kind = pps_pkg::REQ_PRINT_DONE;
            else if (pick < 65) kind = pps_pkg::REQ_DISK;
            else if (pick < 75) kind = pps_pkg::REQ_DISK_DONE;
            else if (pick < 97) kind = pps_pkg::REQ_TERM;
            else kind = 3'($urandom_range(6, 7));
            mem = tight ? 20'($urandom_range(0, 300)) :
                  ($urandom_range(0, 9) == 0) ? 20'($urandom) : 20'($urandom_range(0, 4000));
            send_req(kind, 8'($urandom), mem, ($urandom_range(0, 4) == 0));
        end
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: bad codes, empty queues, extremes, equal priorities, preemption
        send_req(3'd6, 8'hFF, 20'hFFFFF, 1'b0);
        send_req(3'd7, 8'h00, 20'h0, 1'b0);
        send_req(pps_pkg::REQ_TERM, 8'd0, 20'd0, 1'b0);
        send_req(pps_pkg::REQ_PRINT, 8'd0, 20'd0, 1'b0);
        send_req(pps_pkg::REQ_DISK_DONE, 8'd0, 20'd0, 1'b0);
        send_req(pps_pkg::REQ_PRINT_DONE, 8'd0, 20'd0, 1'b0);
        send_req(pps_pkg::REQ_ADD, 8'd10, 20'd100, 1'b0);
        send_req(pps_pkg::REQ_ADD, 8'd10, 20'd100, 1'b0);
        send_req(pps_pkg::REQ_ADD, 8'd10, 20'd100, 1'b0);
        send_req(pps_pkg::REQ_ADD, 8'hFF, 20'd0, 1'b0);
        send_req(pps_pkg::REQ_ADD, 8'h00, 20'd5, 1'b0);
        send_req(pps_pkg::REQ_ADD, 8'd1, 20'hFFFFF, 1'b0);
        send_req(pps_pkg::REQ_PRINT, 8'd0, 20'd0, 1'b0);
        send_req(pps_pkg::REQ_DISK, 8'd0, 20'd0, 1'b0);
        send_req(pps_pkg::REQ_DISK, 8'd0, 20'd0, 1'b0);
        send_req(pps_pkg::REQ_PRINT_DONE, 8'd0, 20'd0, 1'b0);
        send_req(pps_pkg::REQ_DISK_DONE, 8'd0, 20'd0, 1'b0);
        send_req(pps_pkg::REQ_TERM, 8'd0, 20'd0, 1'b0);
        for (int i = 0; i < 6; i++) send_req(pps_pkg::REQ_ADD, 8'($urandom), 20'd1, 1'b0);
        drain();

        // tiny memory and zero limits: no-memory and full fifos
        cfg_write(pps_pkg::CFG_TOTAL_MEM, 20'd0);
        cfg_write(pps_pkg::CFG_PRINT_LIM, 20'd0);
        cfg_write(pps_pkg::CFG_DISK_LIM, 20'd0);
        random_phase(150, 1'b1);
        drain();

        // limits above the fifo depth, moderate memory, ready queue fills up
        cfg_write(pps_pkg::CFG_TOTAL_MEM, 20'd20000);
        cfg_write(pps_pkg::CFG_PRINT_LIM, 20'd7);
        cfg_write(pps_pkg::CFG_DISK_LIM, 20'd5);
        fork
            random_phase(400, 1'b0);
            begin
                repeat (200) @(posedge i_clk);
                hold_off = 1'b1;
            end
        join
        drain();

        cfg_write(pps_pkg::CFG_TOTAL_MEM, 20'd3000);
        cfg_write(pps_pkg::CFG_PRINT_LIM, 20'd1);
        cfg_write(pps_pkg::CFG_DISK_LIM, 20'd2);
        random_phase(500, 1'b1);
        drain();

        cfg_write(pps_pkg::CFG_TOTAL_MEM, 20'hFFFFF);
        cfg_write(pps_pkg::CFG_PRINT_LIM, 20'd4);
        cfg_write(pps_pkg::CFG_DISK_LIM, 20'd3);
        random_phase(950, 1'b0);
        drain();

        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
